/* hw/rtl/rbhc_pkg.sv */
// Shared types, constants and functions for the ROM boot header checker.
`timescale 1ns / 1ps

package rbhc_pkg;

    localparam int HEADER_BYTES_DEF = 4096;
    localparam int CRC_START_DEF    = 64;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] MAX_ROM_RST  = 32'd67108864;

    // Known boot-code CRCs
    localparam logic [31:0] CRC_6101 = 32'h6170_A4A1;
    localparam logic [31:0] CRC_6102 = 32'h90BB_6CB5;
    localparam logic [31:0] CRC_6103 = 32'h0B05_0EE0;
    localparam logic [31:0] CRC_6105 = 32'h98BC_2C86;
    localparam logic [31:0] CRC_6106 = 32'hACC8_580A;

    typedef enum logic [1:0] {
        RES_OK         = 2'd0,
        RES_BAD_SUFFIX = 2'd1,
        RES_BAD_SIZE   = 2'd2,
        RES_BAD_MAGIC  = 2'd3
    } result_code_t;

    typedef enum logic [2:0] {
        CIC_UNKNOWN = 3'd0,
        CIC_6101    = 3'd1,
        CIC_6102    = 3'd2,
        CIC_6103    = 3'd3,
        CIC_6105    = 3'd4,
        CIC_6106    = 3'd5
    } cic_kind_t;

    // One header byte with its side fields
    typedef struct packed {
        logic        suffix_ok;
        logic [31:0] rom_size;
        logic [7:0]  header_byte;
    } rbhc_item_t;

    // One check result
    typedef struct packed {
        cic_kind_t    cic_kind;
        logic [31:0]  code_crc;
        result_code_t result_code;
    } rbhc_result_t;

    // Magic byte expected at offsets 0..3
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h80;
            2'd1:    val = 8'h37;
            2'd2:    val = 8'h12;
            default: val = 8'h40;
        endcase
        return val;
    endfunction

    // Reflected CRC-32 update by one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Map a final CRC to the boot-chip kind
    function automatic cic_kind_t kind_of(input logic [31:0] crc);
        cic_kind_t k;
        case (crc)
            CRC_6101: k = CIC_6101;
            CRC_6102: k = CIC_6102;
            CRC_6103: k = CIC_6103;
            CRC_6105: k = CIC_6105;
            CRC_6106: k = CIC_6106;
            default:  k = CIC_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

/* hw/rtl/rbhc_in_stage.sv */
// Input register stage for header byte transactions.
`timescale 1ns / 1ps

module rbhc_in_stage
    import rbhc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  rbhc_item_t s_item,
    output logic       q_valid,
    input  logic       q_ready,
    output rbhc_item_t q_item
);

    logic       vld_reg, vld_next;
    rbhc_item_t item_reg;

    // Take a new transaction when empty or when the held one moves on
    assign s_ready  = !vld_reg || q_ready;
    assign vld_next = s_valid ? 1'b1 : (vld_reg && !q_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= vld_next;
        end
    end

    // Hold payload until replaced
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign q_valid = vld_reg;
    assign q_item  = item_reg;

endmodule

/* hw/rtl/rbhc_check.sv */
// Per-byte header checks, CRC update and result register.
`timescale 1ns / 1ps

module rbhc_check
    import rbhc_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int CRC_START    = CRC_START_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [31:0]  max_rom_bytes,
    input  logic         q_valid,
    output logic         q_ready,
    input  rbhc_item_t   q_item,
    output logic         m_valid,
    input  logic         m_ready,
    output rbhc_result_t m_result
);

    localparam int          OFF_W    = $clog2(HEADER_BYTES);
    localparam logic [OFF_W-1:0] OFF_LAST  = OFF_W'(HEADER_BYTES - 1);
    localparam logic [OFF_W-1:0] OFF_CRC   = OFF_W'(CRC_START);
    localparam logic [31:0]      HDR_BYTES = 32'(HEADER_BYTES);

    logic [OFF_W-1:0] off_reg, off_next;
    logic [31:0]      crc_reg, crc_next;
    result_code_t     early_reg, early_next;
    logic             magic_reg, magic_next;
    logic             out_vld_reg, out_vld_next;
    rbhc_result_t     out_reg, out_next;

    logic is_last;
    logic advance;
    logic size_bad;

    assign is_last = (off_reg == OFF_LAST);
    // Stall only the last byte while an unread result blocks the output
    assign q_ready = !is_last || !out_vld_reg || m_ready;
    assign advance = q_valid && q_ready;

    // Size rule: at least a header, within the limit, even
    assign size_bad = (q_item.rom_size < HDR_BYTES) || (q_item.rom_size > max_rom_bytes)
                    || q_item.rom_size[0];

    // Evaluate this byte against the running state
    always_comb begin
        early_next = early_reg;
        if (off_reg == '0) begin
            if (!q_item.suffix_ok) begin
                early_next = RES_BAD_SUFFIX;
            end else if (size_bad) begin
                early_next = RES_BAD_SIZE;
            end else begin
                early_next = RES_OK;
            end
        end

        magic_next = magic_reg;
        if (off_reg < OFF_W'(4) && q_item.header_byte != magic_byte(off_reg[1:0])) begin
            magic_next = 1'b0;
        end

        crc_next = crc_reg;
        if (off_reg >= OFF_CRC) begin
            crc_next = crc_byte(crc_reg, q_item.header_byte);
        end

        off_next = off_reg + OFF_W'(1);
    end

    // Build the result of the last byte
    always_comb begin
        out_next.result_code = early_next;
        out_next.code_crc    = '0;
        out_next.cic_kind    = CIC_UNKNOWN;
        if (early_next == RES_OK && !magic_next) begin
            out_next.result_code = RES_BAD_MAGIC;
        end
        if (out_next.result_code == RES_OK) begin
            out_next.code_crc = ~crc_next;
            out_next.cic_kind = kind_of(~crc_next);
        end
    end

    assign out_vld_next = (advance && is_last) ? 1'b1 : (out_vld_reg && !m_ready);

    // Advance run state; clear it after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg     <= '0;
            crc_reg     <= CRC_INIT;
            early_reg   <= RES_OK;
            magic_reg   <= 1'b1;
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
            if (advance) begin
                if (is_last) begin
                    off_reg   <= '0;
                    crc_reg   <= CRC_INIT;
                    early_reg <= RES_OK;
                    magic_reg <= 1'b1;
                end else begin
                    off_reg   <= off_next;
                    crc_reg   <= crc_next;
                    early_reg <= early_next;
                    magic_reg <= magic_next;
                end
            end
        end
    end

    // Load result payload
    always_ff @(posedge aclk) begin
        if (advance && is_last) begin
            out_reg <= out_next;
        end
    end

    assign m_valid  = out_vld_reg;
    assign m_result = out_reg;

endmodule

/* hw/rtl/rom_boot_header_check_core.sv */
// The last header byte passes the input stage, then the result register of rbhc_check.
// Throughput: one header byte per cycle; the byte-wide CRC step sits in one register stage.
// A header of HEADER_BYTES bytes gives one result; the last byte waits only on a full output.
// Reset: synchronous, active low; clears run state and max_rom_bytes to 64 MiB.
// Configuration writes are taken in any cycle and apply at the next byte 0.
`timescale 1ns / 1ps

module rom_boot_header_check_core
    import rbhc_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int CRC_START    = CRC_START_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: max_rom_bytes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // Header bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] header_byte, [39:8] rom_size
    input  logic [0:0]  s_tuser,   // [0] suffix_ok
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [1:0] result_code, [33:2] code_crc, [36:34] cic_kind, 0 pad
);

    logic [31:0]  max_rom_reg;
    rbhc_item_t   s_item, q_item;
    logic         q_valid, q_ready;
    rbhc_result_t m_result;

    // Store the size limit
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_rom_reg <= MAX_ROM_RST;
        end else if (cfg_valid) begin
            max_rom_reg <= cfg_data;
        end
    end

    assign s_item.header_byte = s_tdata[7:0];
    assign s_item.rom_size    = s_tdata[39:8];
    assign s_item.suffix_ok   = s_tuser[0];

    rbhc_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    rbhc_check #(
        .HEADER_BYTES (HEADER_BYTES),
        .CRC_START    (CRC_START)
    ) u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .max_rom_bytes (max_rom_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_result      (m_result)
    );

    assign m_tdata = {3'd0, m_result};

endmodule
